@@ src/lz_token_decoder_core_defines.svh @@
// assertion macros for the lz token decoder
// no dependencies; taken in by the files that carry assertions
`ifndef LZ_TOKEN_DECODER_CORE_DEFINES_SVH
`define LZ_TOKEN_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// implication property checked on every clock edge outside reset
`define LZTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication property
`define LZTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LZTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LZTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/lztd_pkg.sv @@
// shared types, constants and code tables of the lz token decoder
// no dependencies
package lztd_pkg;

  localparam int TN_W   = 14;
  localparam int ACC_W  = 41;
  localparam int HELD_W = 6;
  localparam int OLEN_W = 24;

  // header state codes
  localparam logic [1:0] HDR_TOKENS = 2'd2;
  localparam logic [1:0] HDR_HALTED = 2'd3;

  // decoded token types
  localparam logic [1:0] TK_LIT   = 2'd0;
  localparam logic [1:0] TK_MATCH = 2'd1;
  localparam logic [1:0] TK_OVER  = 2'd2;

  // token kinds on the output
  localparam logic KIND_LIT   = 1'b0;
  localparam logic KIND_MATCH = 1'b1;

  typedef struct packed {
    logic        token_kind;
    logic [7:0]  literal_value;
    logic [15:0] match_distance;
    logic [7:0]  match_length;
    logic        block_done;
    logic        format_error;
    logic        last_of_input;
  } lztd_res_t;

  function automatic logic [13:0] class_base(input logic [3:0] c);
    logic [13:0] r;
    case (c)
      4'd0:    r = 14'd0;
      4'd1:    r = 14'd1;
      default: r = 14'd1 << (c - 4'd1);
    endcase
    return r;
  endfunction

  function automatic logic [3:0] class_extra(input logic [3:0] c);
    logic [3:0] r;
    case (c)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd0;
      default: r = c - 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] code_to_class(input logic [3:0] code);
    logic [3:0] r;
    case (code)
      4'd0:    r = 4'd6;
      4'd1:    r = 4'd7;
      4'd2:    r = 4'd8;
      4'd3:    r = 4'd9;
      4'd4:    r = 4'd10;
      4'd5:    r = 4'd4;
      4'd6:    r = 4'd5;
      4'd7:    r = 4'd11;
      4'd8:    r = 4'd12;
      4'd9:    r = 4'd1;
      4'd10:   r = 4'd2;
      4'd11:   r = 4'd3;
      4'd12:   r = 4'd13;
      4'd13:   r = 4'd0;
      default: r = 4'd14;
    endcase
    return r;
  endfunction

  function automatic logic class_len_bonus(input logic [3:0] c);
    return (c >= 4'd11);
  endfunction

endpackage

@@ src/lztd_if.sv @@
// valid/ready channel interfaces for the lz token decoder
// no dependencies; the output fields mirror the lztd_pkg result struct
interface lztd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface lztd_out_if;
  logic        valid;
  logic        ready;
  logic        token_kind;
  logic [7:0]  literal_value;
  logic [15:0] match_distance;
  logic [7:0]  match_length;
  logic        block_done;
  logic        format_error;
  logic        last_of_input;

  modport source (output valid, output token_kind, output literal_value,
                  output match_distance, output match_length, output block_done,
                  output format_error, output last_of_input, input ready);
  modport sink (input valid, input token_kind, input literal_value,
                input match_distance, input match_length, input block_done,
                input format_error, input last_of_input, output ready);
endinterface

@@ src/lz_token_decoder_core.sv @@
// lz token decoder top level: bit parser, token position table and sequencer
// depends on lztd_pkg, lztd_if and lz_token_decoder_core_defines.svh
// One compressed byte is taken at a time and the input stays not ready until
// every token it completes has been handed to the output register. A header
// byte is accepted and then handed to the output register. A token byte is
// accepted, aligned and decoded (with a second decode step when the partial
// token starts as a match) to find that the next token is still incomplete;
// each token it completes adds decode, two reads and one write of the 16K x 16
// position table (one read and one write port), length accounting and hand-off,
// while an overlong prefix skips the reads and the write. A byte that ends its
// block or completes a fourth token skips the trailing decode. Any wait on the
// output side holds the sequence in the hand-off. No clearing pass after reset:
// table entries 0 to 2 read as their preset values until written.
`include "lz_token_decoder_core_defines.svh"

module lz_token_decoder_core
  import lztd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [OLEN_W-1:0]   cfg_wdata_i,
  lztd_in_if.sink             in_i,
  lztd_out_if.source          out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALIGN = 4'd1;
  localparam logic [3:0] S_DEC1  = 4'd2;
  localparam logic [3:0] S_DEC2  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_RDA   = 4'd5;
  localparam logic [3:0] S_RDB   = 4'd6;
  localparam logic [3:0] S_CALC  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam int TOK_HIST = 1 << TN_W;

  logic [3:0]        state_q, state_d, ret_q, ret_d;
  logic [1:0]        hdr_q, hdr_d;
  logic [TN_W-1:0]   tn_q, tn_d;
  logic [OLEN_W-1:0] bp_q, bp_d, ol_q, ol_d;
  logic [ACC_W-1:0]  acc_q, acc_d, win_q, win_d;
  logic [HELD_W-1:0] held_q, held_d, need_q, need_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [2:0]        pre_q, pre_d;
  logic              pend_v_q, pend_v_d, last_q, last_d, ov_q, ov_d;
  lztd_res_t         pend_q, pend_d, out_q, out_d;
  logic [1:0]        typ_q, typ_d;
  logic [7:0]        lit_q, lit_d, tlen_q, tlen_d;
  logic [TN_W-1:0]   off_q, off_d;
  logic [6:0]        dlen_q, dlen_d;
  logic [15:0]       a_q, a_d;

  // position table
  logic [15:0]       mem_q [TOK_HIST];
  logic [15:0]       mem_rd_q;
  logic [TN_W-1:0]   rd_addr, rd_addr_q, wr_addr;
  logic [15:0]       wr_data, rd_data;
  logic              wr_en, pre_hit;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    mem_rd_q  <= mem_q[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // preset entries read as their reset value until written
  always_comb begin
    case (rd_addr_q[1:0])
      2'd0:    pre_hit = pre_q[0];
      2'd1:    pre_hit = pre_q[1];
      2'd2:    pre_hit = pre_q[2];
      default: pre_hit = 1'b0;
    endcase
    if (rd_addr_q[TN_W-1:2] != '0) begin
      pre_hit = 1'b0;
    end
    rd_data = pre_hit ? (16'(rd_addr_q) + 16'd1) : mem_rd_q;
  end

  // decode helpers
  logic [2:0]        ones;
  logic              run;
  logic [ACC_W-1:0]  w2, w3, w4;
  logic [2:0]        lenbits;
  logic [5:0]        t6;
  logic [3:0]        code, cls, ext_w;
  logic [2:0]        pl;
  logic [12:0]       ext;
  logic [HELD_W:0]   total_need;
  logic [HELD_W-1:0] held_eff, held_n;
  logic [ACC_W-1:0]  acc_eff;
  logic [1:0]        hdr_eff;
  logic [OLEN_W-1:0] bp_eff;
  logic [7:0]        adv_len;
  logic [OLEN_W:0]   total;
  logic [15:0]       b_val;

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    hdr_d    = hdr_q;
    tn_d     = tn_q;
    bp_d     = bp_q;
    ol_d     = cfg_we_i ? cfg_wdata_i : ol_q;
    acc_d    = acc_q;
    win_d    = win_q;
    held_d   = held_q;
    need_d   = need_q;
    cnt_d    = cnt_q;
    pre_d    = pre_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    last_d   = last_q;
    ov_d     = ov_q;
    out_d    = out_q;
    typ_d    = typ_q;
    lit_d    = lit_q;
    tlen_d   = tlen_q;
    off_d    = off_q;
    dlen_d   = dlen_q;
    a_d      = a_q;
    rd_addr  = tn_q + TN_W'(1);
    wr_en    = 1'b0;
    wr_addr  = tn_q + TN_W'(2);
    wr_data  = '0;
    held_eff = held_q;
    acc_eff  = acc_q;
    hdr_eff  = hdr_q;
    bp_eff   = bp_q;
    held_n   = '0;
    adv_len  = '0;
    total    = '0;
    b_val    = rd_data;
    ones     = '0;
    run      = 1'b1;
    w2       = '0;
    w3       = '0;
    w4       = '0;
    lenbits  = '0;
    t6       = '0;
    code     = '0;
    pl       = '0;
    cls      = '0;
    ext_w    = '0;
    ext      = '0;
    total_need = '0;

    // output register drains independently
    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cnt_d = '0;
          if (in_i.frame_start) begin
            hdr_eff  = '0;
            bp_eff   = '0;
            held_eff = '0;
            acc_eff  = '0;
            tn_d     = TN_W'(1);
            pre_d    = 3'b111;
          end
          hdr_d  = hdr_eff;
          bp_d   = bp_eff;
          held_d = held_eff;
          acc_d  = acc_eff;
          if (hdr_eff == HDR_HALTED) begin
            state_d = S_IDLE;
          end else if (hdr_eff != HDR_TOKENS) begin
            // raw header literal
            hdr_d = hdr_eff + 2'd1;
            total = {1'b0, bp_eff} + (OLEN_W+1)'(1);
            if (total >= {1'b0, ol_q}) begin
              hdr_d = HDR_HALTED;
            end
            bp_d   = total[OLEN_W-1:0];
            pend_d = '{token_kind: KIND_LIT, literal_value: in_i.data_byte,
                       match_distance: '0, match_length: '0,
                       block_done: (total == {1'b0, ol_q}),
                       format_error: (total > {1'b0, ol_q}), last_of_input: 1'b0};
            pend_v_d = 1'b1;
            last_d   = 1'b1;
            ret_d    = S_IDLE;
            state_d  = S_EMIT;
          end else begin
            // shift the byte into the bit accumulator
            held_n  = held_eff + HELD_W'(8);
            acc_d   = ((acc_eff << 8) | ACC_W'(in_i.data_byte))
                      & ~({ACC_W{1'b1}} << held_n);
            held_d  = held_n;
            state_d = S_ALIGN;
          end
        end
      end

      // left-justify the held bits
      S_ALIGN: begin
        win_d   = acc_q << (HELD_W'(ACC_W) - held_q);
        state_d = S_DEC1;
      end

      // flag, literal, unary length prefix and its extra bits
      S_DEC1: begin
        for (int i = 0; i < 7; i++) begin
          run = run & win_q[ACC_W-2-i];
          ones = ones + 3'(run);
        end
        if (!win_q[ACC_W-1]) begin
          typ_d   = TK_LIT;
          lit_d   = win_q[ACC_W-2 -: 8];
          need_d  = HELD_W'(9);
          state_d = S_CHK;
        end else if (run) begin
          typ_d   = TK_OVER;
          need_d  = HELD_W'(8);
          state_d = S_CHK;
        end else begin
          typ_d   = TK_MATCH;
          w2      = win_q << (4'(ones) + 4'd2);
          lenbits = (ones == 3'd0) ? 3'd1 : ones;
          t6      = w2[ACC_W-1 -: 6] >> (3'd6 - ones);
          dlen_d  = (ones == 3'd0) ? 7'(w2[ACC_W-1]) : ((7'd1 << ones) + 7'(t6));
          win_d   = w2 << lenbits;
          need_d  = HELD_W'(ones) + HELD_W'(lenbits) + HELD_W'(2);
          state_d = S_DEC2;
        end
      end

      // offset class prefix and its extra bits
      S_DEC2: begin
        w3 = win_q;
        if (!w3[ACC_W-1]) begin
          code = {2'b00, w3[ACC_W-2 -: 2]};
          pl   = 3'd3;
        end else if (w3[ACC_W-2]) begin
          code = 4'd5 + {2'b00, w3[ACC_W-3 -: 2]};
          pl   = 3'd4;
        end else if (!w3[ACC_W-3]) begin
          code = 4'd4;
          pl   = 3'd3;
        end else if (w3[ACC_W-4 -: 2] != 2'b11) begin
          code = 4'd9 + {2'b00, w3[ACC_W-4 -: 2]};
          pl   = 3'd5;
        end else if (!w3[ACC_W-6]) begin
          code = 4'd12;
          pl   = 3'd6;
        end else begin
          code = 4'd13 + {3'b000, w3[ACC_W-7]};
          pl   = 3'd7;
        end
        cls   = code_to_class(code);
        ext_w = class_extra(cls);
        w4    = w3 << pl;
        ext   = w4[ACC_W-1 -: 13] >> (4'd13 - ext_w);
        off_d = class_base(cls) + TN_W'(ext);
        tlen_d = 8'(dlen_q) + 8'(class_len_bonus(cls));
        total_need = (HELD_W+1)'(need_q) + (HELD_W+1)'(pl) + (HELD_W+1)'(ext_w);
        need_d = total_need[HELD_W-1:0];
        state_d = S_CHK;
      end

      // check for a complete token: consume its bits, flush the previous result
      S_CHK: begin
        if (need_q > held_q) begin
          if (pend_v_q) begin
            last_d  = 1'b1;
            ret_d   = S_IDLE;
            state_d = S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          held_n = held_q - need_q;
          held_d = held_n;
          acc_d  = acc_q & ~({ACC_W{1'b1}} << held_n);
          if (pend_v_q) begin
            last_d  = 1'b0;
            ret_d   = S_RDA;
            state_d = S_EMIT;
          end else begin
            state_d = S_RDA;
          end
        end
      end

      // read end position of the current token
      S_RDA: begin
        rd_addr = tn_q + TN_W'(1);
        if (typ_q == TK_OVER) begin
          hdr_d  = HDR_HALTED;
          pend_d = '{token_kind: KIND_MATCH, literal_value: '0, match_distance: '0,
                     match_length: '0, block_done: 1'b0, format_error: 1'b1,
                     last_of_input: 1'b0};
          pend_v_d = 1'b1;
          state_d  = S_FIN;
        end else begin
          state_d = S_RDB;
        end
      end

      // read end position of the referenced token
      S_RDB: begin
        a_d     = rd_data;
        rd_addr = tn_q - off_q;
        state_d = S_CALC;
      end

      // distance, table update and length accounting
      S_CALC: begin
        b_val   = rd_data;
        adv_len = (typ_q == TK_LIT) ? 8'd1 : (tlen_q + 8'd2);
        wr_en   = 1'b1;
        wr_addr = tn_q + TN_W'(2);
        wr_data = a_q + 16'(adv_len);
        if (wr_addr[TN_W-1:2] == '0) begin
          case (wr_addr[1:0])
            2'd0:    pre_d[0] = 1'b0;
            2'd1:    pre_d[1] = 1'b0;
            2'd2:    pre_d[2] = 1'b0;
            default: pre_d = pre_q;
          endcase
        end
        tn_d  = tn_q + TN_W'(1);
        total = {1'b0, bp_q} + (OLEN_W+1)'(adv_len);
        if (total >= {1'b0, ol_q}) begin
          hdr_d = HDR_HALTED;
        end
        bp_d = total[OLEN_W-1:0];
        pend_d = '{token_kind: (typ_q == TK_LIT) ? KIND_LIT : KIND_MATCH,
                   literal_value: (typ_q == TK_LIT) ? lit_q : 8'd0,
                   match_distance: (typ_q == TK_LIT) ? 16'd0 : (a_q - b_val),
                   match_length: (typ_q == TK_LIT) ? 8'd0 : adv_len,
                   block_done: (total == {1'b0, ol_q}),
                   format_error: (total > {1'b0, ol_q}), last_of_input: 1'b0};
        pend_v_d = 1'b1;
        state_d  = S_FIN;
      end

      // stop after four tokens or when halted
      S_FIN: begin
        if (hdr_q == HDR_HALTED || cnt_q == 3'd3) begin
          last_d  = 1'b1;
          ret_d   = S_IDLE;
          state_d = S_EMIT;
        end else begin
          cnt_d   = cnt_q + 3'd1;
          state_d = S_ALIGN;
        end
      end

      // hand the pending result to the output register
      S_EMIT: begin
        if (!ov_q || out_o.ready) begin
          out_d = pend_q;
          out_d.last_of_input = last_q;
          ov_d     = 1'b1;
          pend_v_d = 1'b0;
          state_d  = ret_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      hdr_q    <= '0;
      tn_q     <= TN_W'(1);
      bp_q     <= '0;
      ol_q     <= OLEN_W'(2);
      acc_q    <= '0;
      held_q   <= '0;
      cnt_q    <= '0;
      pre_q    <= 3'b111;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      hdr_q    <= hdr_d;
      tn_q     <= tn_d;
      bp_q     <= bp_d;
      ol_q     <= ol_d;
      acc_q    <= acc_d;
      held_q   <= held_d;
      cnt_q    <= cnt_d;
      pre_q    <= pre_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    need_q <= need_d;
    pend_q <= pend_d;
    last_q <= last_d;
    out_q  <= out_d;
    typ_q  <= typ_d;
    lit_q  <= lit_d;
    tlen_q <= tlen_d;
    off_q  <= off_d;
    dlen_q <= dlen_d;
    a_q    <= a_d;
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = ov_q;
  assign out_o.token_kind     = out_q.token_kind;
  assign out_o.literal_value  = out_q.literal_value;
  assign out_o.match_distance = out_q.match_distance;
  assign out_o.match_length   = out_q.match_length;
  assign out_o.block_done     = out_q.block_done;
  assign out_o.format_error   = out_q.format_error;
  assign out_o.last_of_input  = out_q.last_of_input;

  // checks
  `LZTD_ASSERT_IMP(a_held_range, clk_i, rst_ni, 1'b1, held_q <= HELD_W'(ACC_W), "bits held overflow")
  `LZTD_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, state_q != S_IDLE, cnt_q <= 3'd3, "token count overflow")
  `LZTD_ASSERT_NEXT(a_halt_on_err, clk_i, rst_ni, state_q == S_CALC && total > {1'b0, ol_q}, hdr_q == HDR_HALTED, "overshoot did not halt")

endmodule
